// ----- rtl/qcpq_pkg.sv -----
// Shared types, constants and helper functions for the quarter-cycle P/Q filter.
`timescale 1ns / 1ps

package qcpq_pkg;

  localparam int DEPTH     = 64;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int DELAY_W   = 7;
  localparam int FRAC_BITS = 15;

  // Reciprocal of 100 scaled by 2^RECIP_SHIFT, rounded up; exact for |x| <= 2^30.
  localparam int RECIP_SHIFT = 37;
  localparam logic signed [31:0] RECIP_100 = 32'sd1374389535;

  localparam logic [6:0]         QDELAY_RST   = 7'd1;
  localparam logic [7:0]         RATE_RST     = 8'd200;
  localparam logic signed [15:0] GAIN_IN_RST  = 16'sd3277;
  localparam logic signed [15:0] GAIN_OUT_RST = 16'sd29491;

  typedef enum logic [1:0] {
    REG_QUARTER_DELAY = 2'd0,
    REG_SAMPLE_RATE   = 2'd1,
    REG_GAIN_IN       = 2'd2,
    REG_GAIN_OUT      = 2'd3
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROD_P,
    ST_PROD_Q,
    ST_SCALE_P,
    ST_SCALE_Q,
    ST_FILT_P0,
    ST_FILT_P1,
    ST_FILT_Q0,
    ST_FILT_Q1,
    ST_FIN
  } state_t;

  // Round half up at the gain binary point, then clamp to signed 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [63:0] sum);
    logic signed [63:0] t;
    logic signed [31:0] r;
    t = (sum + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (t < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  // Finish a divide by 100: take the scaled magnitude and restore the sign.
  function automatic logic signed [31:0] div100_finish(input logic neg,
                                                       input logic signed [63:0] prod);
    logic signed [31:0] mag;
    mag = {5'b0, prod[63:RECIP_SHIFT]};
    return neg ? -mag : mag;
  endfunction

  function automatic logic signed [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? -x : x;
  endfunction

endpackage

// ----- rtl/quarter_cycle_pq_power_filter.sv -----
// Quarter-cycle delay P/Q power estimator with first-order output smoothing.
`timescale 1ns / 1ps

// Each input beat carries one voltage and one current sample. Active power is
// voltage*current and reactive power is the voltage from a quarter period back
// times current; both pass a first-order IIR filter with Q1.15 gains and come
// out saturated to signed 32 bits, one output beat per input beat. Plain mode
// (tuser 0) takes the delay from quarter_delay; droop mode (tuser 1) derives it
// as ceil(sample_rate / (4 * line_freq)) and scales both products by 1/100.
// Until the delayed sample has been stored, or while the delay is zero, the quadrature voltage reads as -1.
// All products go through one 32x32 multiplier under a small sequencer, and the
// droop delay comes from a 7-step restoring divider. A new input beat is accepted
// only once the previous item is done, and an item can wait in ST_FIN on
// m_axis_tready while a previous result is still unread.
module quarter_cycle_pq_power_filter
  import qcpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // voltage[15:0], current[31:16], line_freq[39:32]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // p_filt[31:0], q_filt[63:32]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  state_t state, state_next;

  // configuration
  logic [6:0]         quarter_delay;
  logic [7:0]         sample_rate;
  logic signed [15:0] gain_in;
  logic signed [15:0] gain_out;

  // persistent filter and ring state
  logic [15:0]        mem [DEPTH];
  logic [PTR_W-1:0]   wp;
  logic [CNT_W-1:0]   stored;
  logic signed [31:0] filt_act;
  logic signed [31:0] filt_react;

  // per-item working registers
  logic               droop;
  logic signed [15:0] volt;
  logic signed [15:0] curr;
  logic [7:0]         freq;
  logic [9:0]         rem;
  logic [DELAY_W-1:0] quo;        // divider quotient, then the delay itself
  logic [2:0]         div_cnt;
  logic               qv_ok;
  logic [15:0]        rd_data;
  logic signed [31:0] p_val;
  logic signed [31:0] q_val;
  logic signed [63:0] prod;
  logic signed [63:0] acc;

  logic               accept;
  logic               fin_go;
  logic [10:0]        div_num;
  logic [9:0]         den;
  logic [10:0]        trial;
  logic               trial_ge;
  logic [PTR_W-1:0]   rd_idx;
  logic signed [31:0] qv;
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] react_new;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fin_go        = !m_axis_tvalid || m_axis_tready;

  assign div_num  = {3'b0, sample_rate} + {1'b0, s_axis_tdata[39:32], 2'b00} - 11'd1;
  assign den      = {freq, 2'b00};
  assign trial    = {rem, quo[DELAY_W-1]};
  assign trial_ge = (trial >= {1'b0, den});
  assign rd_idx   = wp - quo[PTR_W-1:0];
  assign qv       = qv_ok ? 32'(signed'(rd_data)) : -32'sd1;
  assign react_new = round_sat(acc + prod);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PROD_P: begin
        mul_a = 32'(volt);
        mul_b = 32'(curr);
      end
      ST_PROD_Q: begin
        mul_a = qv;
        mul_b = 32'(curr);
      end
      ST_SCALE_P: begin
        mul_a = abs32(p_val);
        mul_b = RECIP_100;
      end
      ST_SCALE_Q: begin
        mul_a = abs32(q_val);
        mul_b = RECIP_100;
      end
      ST_FILT_P0: begin
        mul_a = 32'(gain_in);
        mul_b = p_val;
      end
      ST_FILT_P1: begin
        mul_a = 32'(gain_out);
        mul_b = filt_act;
      end
      ST_FILT_Q0: begin
        mul_a = 32'(gain_in);
        mul_b = q_val;
      end
      // hold the last filter product while the result waits in ST_FIN
      ST_FILT_Q1, ST_FIN: begin
        mul_a = 32'(gain_out);
        mul_b = filt_react;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser && (s_axis_tdata[39:32] != 8'd0)) begin
            state_next = ST_DIV;
          end else begin
            state_next = ST_PROD_P;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == 3'(DELAY_W - 1)) begin
          state_next = ST_PROD_P;
        end
      end
      ST_PROD_P:  state_next = ST_PROD_Q;
      ST_PROD_Q:  state_next = droop ? ST_SCALE_P : ST_FILT_P0;
      ST_SCALE_P: state_next = ST_SCALE_Q;
      ST_SCALE_Q: state_next = ST_FILT_P0;
      ST_FILT_P0: state_next = ST_FILT_P1;
      ST_FILT_P1: state_next = ST_FILT_Q0;
      ST_FILT_Q0: state_next = ST_FILT_Q1;
      ST_FILT_Q1: state_next = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_delay <= QDELAY_RST;
      sample_rate   <= RATE_RST;
      gain_in       <= GAIN_IN_RST;
      gain_out      <= GAIN_OUT_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_QUARTER_DELAY: quarter_delay <= cfg_wdata[6:0];
        REG_SAMPLE_RATE:   sample_rate   <= cfg_wdata[7:0];
        REG_GAIN_IN:       gain_in       <= signed'(cfg_wdata);
        REG_GAIN_OUT:      gain_out      <= signed'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // sample ring: registered read, write at the end of each item
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_idx];
    if (state == ST_FIN && fin_go) begin
      mem[wp] <= volt;
    end
  end

  // control state: ring pointers, filter state, output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      wp            <= '0;
      stored        <= '0;
      filt_act      <= '0;
      filt_react    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && fin_go) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_FILT_Q0) begin
        filt_act <= round_sat(acc + prod);
      end
      if (state == ST_FIN && fin_go) begin
        filt_react    <= react_new;
        wp            <= wp + 1'b1;
        if (stored != CNT_W'(DEPTH)) begin
          stored <= stored + 1'b1;
        end
      end
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          droop   <= s_axis_tuser;
          volt    <= signed'(s_axis_tdata[15:0]);
          curr    <= signed'(s_axis_tdata[31:16]);
          freq    <= s_axis_tdata[39:32];
          div_cnt <= '0;
          rem     <= {6'b0, div_num[10:7]};
          if (s_axis_tuser) begin
            // zero frequency leaves the delay at zero
            quo <= (s_axis_tdata[39:32] != 8'd0) ? div_num[6:0] : '0;
          end else begin
            quo <= quarter_delay;
          end
        end
      end
      ST_DIV: begin
        rem     <= trial_ge ? 10'(trial - {1'b0, den}) : trial[9:0];
        quo     <= {quo[DELAY_W-2:0], trial_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_PROD_P: begin
        qv_ok <= (quo != '0) && (quo <= stored);
      end
      ST_PROD_Q: begin
        p_val <= prod[31:0];
      end
      ST_SCALE_P: begin
        q_val <= prod[31:0];
      end
      ST_SCALE_Q: begin
        p_val <= div100_finish(p_val[31], prod);
      end
      ST_FILT_P0: begin
        q_val <= droop ? div100_finish(q_val[31], prod) : prod[31:0];
      end
      ST_FILT_P1: begin
        acc <= prod;
      end
      ST_FILT_Q1: begin
        acc <= prod;
      end
      ST_FIN: begin
        if (fin_go) begin
          m_axis_tdata <= {react_new, filt_act};
        end
      end
      default: ;
    endcase
  end

endmodule
